FILE: rtl/core/pedestal_running_mean_variance_assert.svh
// assertion macros shared by the pedestal statistics rtl
`ifndef PEDESTAL_RUNNING_MEAN_VARIANCE_ASSERT_SVH
`define PEDESTAL_RUNNING_MEAN_VARIANCE_ASSERT_SVH

// property checked on every clock edge outside reset
`define PRMV_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define PRMV_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/prmv_pkg.sv
// types and constants of the pedestal running mean and variance block
package prmv_pkg;

  localparam int unsigned CHANNELS = 1024;
  localparam int unsigned BUCKETS  = 4;
  localparam int unsigned RANGES   = 2;
  localparam int unsigned SENSORS  = 4;

  localparam int unsigned ENTRIES = CHANNELS * BUCKETS * RANGES * SENSORS;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int unsigned MEAN_W   = 23;
  localparam int unsigned SPREAD_W = 56;
  localparam int unsigned COUNT_W  = 16;

  localparam logic [1:0]          TYPE_DATA  = 2'd0;
  localparam logic [MEAN_W-1:0]   MEAN_MAX   = '1;
  localparam logic [SPREAD_W-1:0] SPREAD_MAX = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

  // shared divider geometry
  localparam int unsigned DIV_REM_W = 29;
  localparam int unsigned DIV_DVD_W = 34;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MEAN   = 6'd24;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SPREAD = 6'd34;

  typedef struct packed {
    logic [1:0]  sample_type;
    logic [9:0]  channel;
    logic [1:0]  bucket;
    logic        gain_range;
    logic [1:0]  sensor;
    logic [12:0] sample_value;
    logic        restart;
  } prmv_in_t;

  typedef struct packed {
    logic                accumulated;
    logic [MEAN_W-1:0]   mean_value;
    logic [SPREAD_W-1:0] spread_sum;
    logic [COUNT_W-1:0]  sample_count;
  } prmv_out_t;

  typedef struct packed {
    logic [MEAN_W-1:0]   mean;
    logic [SPREAD_W-1:0] spread;
    logic [COUNT_W-1:0]  count;
  } prmv_entry_t;

  typedef struct packed {
    logic             go;
    logic             ok;
    logic [IDX_W-1:0] idx;
    logic [12:0]      value;
    logic             restart;
  } prmv_req_t;

  typedef struct packed {
    logic ready;
    logic res_valid;
  } prmv_core_sts_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_REM_W-1:0] rem_init;
    logic [DIV_DVD_W-1:0] dvd;
    logic [DIV_REM_W-1:0] den;
  } prmv_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } prmv_div_sts_t;

endpackage

FILE: rtl/core/prmv_div.sv
// shared restoring divider, one quotient bit per cycle
module prmv_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  prmv_pkg::prmv_div_req_t          req,
  output prmv_pkg::prmv_div_sts_t          sts,
  output logic [prmv_pkg::DIV_DVD_W-1:0]   quot
);
  import prmv_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [DIV_REM_W-1:0] rem_r;
  logic [DIV_DVD_W-1:0] dvd_r;
  logic [DIV_REM_W-1:0] den_r;

  logic                 busy;
  logic [DIV_REM_W:0]   rem_sh;
  logic [DIV_REM_W+1:0] diff;
  logic                 qbit;
  logic [DIV_REM_W-1:0] rem_nxt;

  assign busy   = (cnt_r != '0);
  assign rem_sh = {rem_r, dvd_r[DIV_DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign qbit   = ~diff[DIV_REM_W+1];
  assign rem_nxt = qbit ? diff[DIV_REM_W-1:0] : rem_sh[DIV_REM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy && (cnt_r == DIV_CNT_W'(1));
      if (req.start) begin
        cnt_r <= req.steps;
      end else if (busy) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      dvd_r <= req.dvd;
      den_r <= req.den;
    end else if (busy) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DIV_DVD_W-2:0], qbit};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done_r;
  assign quot     = dvd_r;

endmodule

FILE: rtl/core/prmv_core.sv
// entry store and update sequencer around the shared divider and multiplier
`include "pedestal_running_mean_variance_assert.svh"

module prmv_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  prmv_pkg::prmv_req_t       req,
  input  logic                      take,
  output prmv_pkg::prmv_core_sts_t  sts,
  output prmv_pkg::prmv_out_t       res
);
  import prmv_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_MLO   = 4'd3;
  localparam logic [3:0] S_MHI   = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_WAITM = 4'd6;
  localparam logic [3:0] S_WAITS = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  prmv_entry_t store_mem [ENTRIES];
  prmv_entry_t rd_r;

  logic [3:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r;
  logic [12:0]         val_r;
  logic                restart_r;
  logic [MEAN_W-1:0]   mean_r, mean_nxt;
  logic [SPREAD_W-1:0] sp_r;
  logic [COUNT_W-1:0]  n_r;
  logic [COUNT_W:0]    d_r;
  logic                neg_r;
  logic [22:0]         mag_r;
  logic [45:0]         m2_r;
  logic [38:0]         plo_r, phi_r;
  logic [62:0]         num_r;
  prmv_out_t           res_r, res_nxt;

  prmv_entry_t         ent;
  logic [24:0]         delta, delta_abs;
  logic [23:0]         mag_plus;
  logic [23:0]         mul_a, mul_b;
  logic [47:0]         mul_p;
  logic [24:0]         mean_sum;
  logic [SPREAD_W:0]   sp_sum;
  logic [SPREAD_W-1:0] sp_new;
  logic [COUNT_W-1:0]  n_new;
  logic                wr_en;
  prmv_entry_t         wr_ent;

  prmv_div_req_t              div_req;
  prmv_div_sts_t              div_sts;
  logic [DIV_DVD_W-1:0]       div_quot;

  prmv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts),
    .quot  (div_quot)
  );

  // entry as seen by this update, restart wipes it
  assign ent       = restart_r ? prmv_entry_t'('0) : rd_r;
  assign delta     = {2'b00, val_r, 10'b0} - {2'b00, ent.mean};
  assign delta_abs = delta[24] ? (~delta + 25'd1) : delta;
  assign mag_plus  = {1'b0, mag_r} + {8'b0, d_r[COUNT_W:1]};

  // shared multiplier: square, then count times square in two halves
  always_comb begin
    case (state_r)
      S_SQ: begin
        mul_a = {1'b0, mag_r};
        mul_b = {1'b0, mag_r};
      end
      S_MLO: begin
        mul_a = {8'b0, n_r};
        mul_b = {1'b0, m2_r[22:0]};
      end
      S_MHI: begin
        mul_a = {8'b0, n_r};
        mul_b = {1'b0, m2_r[45:23]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // divider operands: mean step first, spread step second
  always_comb begin
    div_req.start = (state_r == S_SQ) || (state_r == S_WAITM && div_sts.done);
    if (state_r == S_SQ) begin
      div_req.steps    = DIV_STEPS_MEAN;
      div_req.rem_init = '0;
      div_req.dvd      = {mag_plus, 10'b0};
      div_req.den      = {12'b0, d_r};
    end else begin
      div_req.steps    = DIV_STEPS_SPREAD;
      div_req.rem_init = num_r[62:34];
      div_req.dvd      = num_r[33:0];
      div_req.den      = {d_r, 12'b0};
    end
  end

  // mean update with clamp
  always_comb begin
    if (neg_r) begin
      mean_sum = {2'b00, mean_r} - {1'b0, div_quot[23:0]};
      mean_nxt = mean_sum[24] ? '0 : mean_sum[MEAN_W-1:0];
    end else begin
      mean_sum = {2'b00, mean_r} + {1'b0, div_quot[23:0]};
      mean_nxt = (mean_sum > {2'b00, MEAN_MAX}) ? MEAN_MAX : mean_sum[MEAN_W-1:0];
    end
  end

  assign sp_sum = {1'b0, sp_r} + (SPREAD_W+1)'(div_quot);
  assign sp_new = (sp_sum >= {1'b0, SPREAD_MAX}) ? SPREAD_MAX : sp_sum[SPREAD_W-1:0];
  assign n_new  = (n_r == COUNT_MAX) ? n_r : n_r + COUNT_W'(1);

  assign wr_en        = (state_r == S_WAITS) && div_sts.done;
  assign wr_ent.mean   = mean_r;
  assign wr_ent.spread = sp_new;
  assign wr_ent.count  = n_new;

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (req.go) begin
          if (req.ok) begin
            state_nxt = S_PREP;
          end else begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_PREP:  state_nxt = S_SQ;
      S_SQ:    state_nxt = S_MLO;
      S_MLO:   state_nxt = S_MHI;
      S_MHI:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_WAITM;
      S_WAITM: begin
        if (div_sts.done) begin
          state_nxt = S_WAITS;
        end
      end
      S_WAITS: begin
        if (div_sts.done) begin
          res_nxt.accumulated  = 1'b1;
          res_nxt.mean_value   = mean_r;
          res_nxt.spread_sum   = sp_new;
          res_nxt.sample_count = n_new;
          state_nxt            = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == S_IDLE && req.go) begin
      idx_r     <= req.idx;
      val_r     <= req.value;
      restart_r <= req.restart;
    end
    if (state_r == S_PREP) begin
      mean_r <= ent.mean;
      sp_r   <= ent.spread;
      n_r    <= ent.count;
      d_r    <= {1'b0, ent.count} + (COUNT_W+1)'(1);
      neg_r  <= delta[24];
      mag_r  <= delta_abs[22:0];
    end
    if (state_r == S_SQ) begin
      m2_r <= mul_p[45:0];
    end
    if (state_r == S_MLO) begin
      plo_r <= mul_p[38:0];
    end
    if (state_r == S_MHI) begin
      phi_r <= mul_p[38:0];
    end
    if (state_r == S_SUM) begin
      // count times square, plus half of (count+1)*4096 for rounding
      num_r <= {24'b0, plo_r} + {1'b0, phi_r, 23'b0} + {35'b0, d_r, 11'b0};
    end
    if (state_r == S_WAITM && div_sts.done) begin
      mean_r <= mean_nxt;
    end
  end

  // entry store: one read on accept, one write at the end
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && req.go) begin
      rd_r <= store_mem[req.idx];
    end
    if (wr_en) begin
      store_mem[idx_r] <= wr_ent;
    end
  end

  assign sts.ready     = (state_r == S_IDLE);
  assign sts.res_valid = (state_r == S_DONE);
  assign res           = res_r;

  `PRMV_CHECK(div_done_in_wait, div_sts.done |-> (state_r == S_WAITM || state_r == S_WAITS), "divider finished outside a wait state")
  `PRMV_CHECK(div_start_idle, div_req.start |-> !div_sts.busy, "divider restarted while busy")
  `PRMV_CHECK_NEXT(accept_leaves_idle, req.go && state_r == S_IDLE, state_r == S_PREP || state_r == S_DONE, "accepted word did not start an update")
  `PRMV_CHECK(write_count_nonzero, wr_en |-> wr_ent.count != '0, "entry written back with zero count")

endmodule

FILE: rtl/core/pedestal_running_mean_variance.sv
// pedestal running mean and variance: top level with input decode and output register
//
// usage
//   in_valid/in_stall/in_word carry one adc sample word; in_stall is high whenever
//   the update sequencer is busy, so one word is in work at a time
//   out_valid/out_stall/out_word carry one result word per input word, in order
//   data samples (type 0) with an in-range channel, bucket, gain range and sensor
//   update their entry (welford step) and return the new mean, spread and count;
//   anything else returns a word with accumulated low and all fields zero
// sequence
//   an accumulating word passes prep, square, two multiply halves, sum and the two
//   passes through the shared one-bit-per-cycle divider (24 and 34 steps), while a
//   rejected word goes straight to done; either word waits in done until the output
//   register takes its result, and only then is the next word accepted
// reset
//   rst_n clears the sequencer, the divider counter and out_valid only; the entry store is
//   not cleared, so the first sample to each entry after reset must set restart
// stall
//   a result waits in the output register while out_stall is high; the core may
//   already accept and work on the next word, and holds its own result until the
//   output register frees up
`include "pedestal_running_mean_variance_assert.svh"

module pedestal_running_mean_variance (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  prmv_pkg::prmv_in_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output prmv_pkg::prmv_out_t  out_word
);
  import prmv_pkg::*;

  prmv_req_t      core_req;
  prmv_core_sts_t core_sts;
  prmv_out_t      core_res;
  logic           take;
  logic           out_free;
  logic [31:0]    idx_full;
  logic           in_range;

  logic           out_valid_r, out_valid_nxt;
  prmv_out_t      out_word_r;

  // flat entry index: channel major, sensor minor
  assign idx_full = ((32'(in_word.channel) * BUCKETS + 32'(in_word.bucket)) * RANGES
                     + 32'(in_word.gain_range)) * SENSORS + 32'(in_word.sensor);

  assign in_range = (32'(in_word.channel) < CHANNELS) && (32'(in_word.bucket) < BUCKETS)
                 && (32'(in_word.gain_range) < RANGES) && (32'(in_word.sensor) < SENSORS);

  assign in_stall         = ~core_sts.ready;
  assign core_req.go      = in_valid & ~in_stall;
  assign core_req.ok      = in_range && (in_word.sample_type == TYPE_DATA);
  assign core_req.idx     = idx_full[IDX_W-1:0];
  assign core_req.value   = in_word.sample_value;
  assign core_req.restart = in_word.restart;

  prmv_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (core_req),
    .take  (take),
    .sts   (core_sts),
    .res   (core_res)
  );

  // output register frees up when empty or being drained this cycle
  assign out_free = ~out_valid_r | ~out_stall;
  assign take     = core_sts.res_valid & out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `PRMV_CHECK(no_overwrite, take |-> !(out_valid_r && out_stall), "result overwrote a stalled output word")
  `PRMV_CHECK_NEXT(accept_blocks_input, in_valid && !in_stall, in_stall, "input accepted while core still busy")
  `PRMV_CHECK_NEXT(take_shows_result, take, out_valid, "result taken but not presented")

endmodule
